@@ rtl/tot_pkg.sv @@
`timescale 1ns / 1ps
package tot_pkg;

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // vector kinds inside one triangle entry
   localparam logic [2:0] KIND_CENTER = 3'd0;
   localparam logic [2:0] KIND_NORMAL = 3'd1;
   localparam logic [2:0] KIND_V1     = 3'd2;
   localparam logic [2:0] KIND_V2     = 3'd3;
   localparam logic [2:0] KIND_V3     = 3'd4;

   // answer codes
   localparam logic [1:0] STATUS_VISIBLE    = 2'd0;
   localparam logic [1:0] STATUS_NOT_FACING = 2'd1;
   localparam logic [1:0] STATUS_OCCLUDED   = 2'd2;

   // control register indexes
   localparam logic CSR_TRIANGLE_COUNT = 1'b0;
   localparam logic CSR_TOLERANCE      = 1'b1;

   localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
   localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

   typedef struct packed {
      logic              req_type;
      logic [9:0]        entry_index;
      logic [2:0]        vec_kind;
      logic signed [31:0] comp_x;
      logic signed [31:0] comp_y;
      logic signed [31:0] comp_z;
      logic [9:0]        from_index;
      logic [9:0]        to_index;
   } req_payload_type;

   typedef struct packed {
      logic       visible;
      logic [1:0] status;
      logic [9:0] blocker_index;
   } rsp_payload_type;

   typedef struct packed {
      logic              done;
      logic              zero;
      logic signed [31:0] quot;
   } div_result_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RD_CI,
      ST_RD_CJ,
      ST_RD_NI,
      ST_RD_NJ,
      ST_DOT_I,
      ST_CHK_I,
      ST_DOT_J,
      ST_CHK_J,
      ST_K_SCAN,
      ST_K_NK,
      ST_K_DEN,
      ST_K_CHK_DEN,
      ST_K_NUM,
      ST_K_DIV_BETA,
      ST_K_WAIT_BETA,
      ST_K_RD_W2,
      ST_K_RD_W3,
      ST_K_PJ,
      ST_K_PK,
      ST_K_UV,
      ST_K_BRANCH,
      ST_K_N1,
      ST_K_N2,
      ST_K_N3,
      ST_K_N4,
      ST_K_N5,
      ST_K_WAIT_B,
      ST_K_A1,
      ST_K_A2,
      ST_K_WAIT_A
   } tot_state_type;

   // pick component i of a packed {z, y, x} vector
   function automatic logic signed [31:0] vec_comp(logic [95:0] v, logic [1:0] i);
      logic [31:0] r;
      unique case (i)
         2'd0: r = v[31:0];
         2'd1: r = v[63:32];
         default: r = v[95:64];
      endcase
      return r;
   endfunction

   function automatic logic signed [63:0] sx64(logic [31:0] x);
      return {{32{x[31]}}, x};
   endfunction

   function automatic logic signed [33:0] ext34(logic [31:0] x);
      return {{2{x[31]}}, x};
   endfunction

   function automatic logic [32:0] mag33(logic [31:0] x);
      return x[31] ? ({1'b0, ~x} + 33'd1) : {1'b0, x};
   endfunction

   function automatic logic signed [31:0] sat64(logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) r = 32'sh7FFF_FFFF;
      else if (v < SAT_MIN) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   // a - b saturated to 32 bit signed
   function automatic logic signed [31:0] sub_sat(logic [31:0] a, logic [31:0] b);
      logic [32:0] d;
      logic [31:0] r;
      d = {a[31], a} - {b[31], b};
      if (d[32] != d[31]) r = d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else r = d[31:0];
      return r;
   endfunction

endpackage

@@ rtl/tot_ram.sv @@
`timescale 1ns / 1ps
module tot_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/tot_div.sv @@
`timescale 1ns / 1ps
module tot_div
   import tot_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic signed [31:0] den,
   output div_result_type     result
);

   localparam int NUMW = 32 + FRAC_BITS;
   localparam int CW   = $clog2(NUMW + 1);
   localparam logic [NUMW-1:0] HALF = NUMW'(64'h8000_0000);

   logic            busy_ff, busy_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [31:0]     rem_ff, rem_in;
   logic [NUMW-1:0] dvd_ff, dvd_in;
   logic [31:0]     dvs_ff, dvs_in;
   logic            neg_ff, neg_in;
   div_result_type  res_ff, res_in;

   logic [32:0] rem_sh, rem_diff, num_mag, den_mag;
   logic        ge;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;
      res_in.done = 1'b0;
      num_mag  = mag33(num);
      den_mag  = mag33(den);
      rem_sh   = {rem_ff, dvd_ff[NUMW-1]};
      ge       = rem_sh >= {1'b0, dvs_ff};
      rem_diff = rem_sh - {1'b0, dvs_ff};
      if (start) begin
         if (den == '0) begin
            res_in.done = 1'b1;
            res_in.zero = 1'b1;
            res_in.quot = '0;
         end else begin
            busy_in = 1'b1;
            cnt_in  = '0;
            rem_in  = '0;
            dvd_in  = {num_mag[31:0], {FRAC_BITS{1'b0}}};
            dvs_in  = den_mag[31:0];
            neg_in  = num[31] ^ den[31];
         end
      end else if (busy_ff) begin
         if (cnt_ff == CW'(NUMW)) begin
            // sign and saturate the magnitude quotient
            busy_in     = 1'b0;
            res_in.done = 1'b1;
            res_in.zero = 1'b0;
            if (neg_ff) begin
               res_in.quot = (dvd_ff > HALF) ? 32'sh8000_0000 : (~dvd_ff[31:0] + 32'd1);
            end else begin
               res_in.quot = (dvd_ff >= HALF) ? 32'sh7FFF_FFFF : dvd_ff[31:0];
            end
         end else begin
            cnt_in = cnt_ff + CW'(1);
            rem_in = ge ? rem_diff[31:0] : rem_sh[31:0];
            dvd_in = {dvd_ff[NUMW-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         res_ff.done <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         res_ff  <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign result = res_ff;

endmodule

@@ rtl/triangle_occlusion_test_top.sv @@
`timescale 1ns / 1ps
// Triangle line-of-sight occlusion test. A write transaction (start with
// req_type 0) stores one vector of a triangle entry. A query transaction
// checks that the source and target normals face each other along the
// center-to-center segment, then scans entries 0 to triangle_count-1 for
// the first one whose triangle the segment passes through, and answers
// with one rsp_strobe cycle carrying visible, status and blocker_index.
// The receiver cannot stall: the answer is shown for exactly one cycle.
// busy stays high for the whole query; a query with an index at or above
// MAX_TRIANGLES answers "not facing" in the next cycle without raising
// busy. In the scan the source and target are skipped, an entry whose
// plane is parallel to the segment is passed over without a division, and
// up to three divisions run for any other entry. The shared bit-serial
// divider produces one quotient bit per cycle; the single read port of
// the entry memory fetches one vector at a time. All vectors live in one
// memory of MAX_TRIANGLES * 8 words of 96 bits with a registered read;
// entries are undefined until written and there is no clearing pass.
module triangle_occlusion_test_top
   import tot_pkg::*;
#(
   parameter int MAX_TRIANGLES = 1024,
   parameter int FRAC_BITS     = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_payload_type req_payload,
   output logic            rsp_strobe,
   output rsp_payload_type rsp_payload,
   input  logic            csr_we,
   input  logic            csr_index,
   input  logic [15:0]     csr_wdata
);

   localparam int EW    = $clog2(MAX_TRIANGLES);
   localparam int AW    = EW + 3;
   localparam int DEPTH = MAX_TRIANGLES * 8;
   localparam int KW    = $clog2(MAX_TRIANGLES + 1);

   // control
   tot_state_type   state_ff, state_in;
   logic [10:0]     count_ff, count_in;
   logic [15:0]     tol_ff, tol_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   // datapath
   logic [9:0]         from_ff, from_in, to_ff, to_in;
   logic [KW-1:0]      k_ff, k_in;
   logic [1:0]         sub_ff, sub_in;
   logic [95:0]        ci_ff, ci_in, s_ff, s_in, sk_ff, sk_in;
   logic [95:0]        va_ff, va_in, nj_ff, nj_in;
   logic signed [63:0] prod_ff, prod_in, acc_ff, acc_in, t_ff, t_in;
   logic signed [31:0] den_ff, den_in, beta_ff, beta_in, bb_ff, bb_in, n_ff, n_in;
   logic signed [31:0] w1j_ff, w1j_in, w1k_ff, w1k_in, w2j_ff, w2j_in, w2k_ff, w2k_in;
   logic signed [31:0] w3j_ff, w3j_in, w3k_ff, w3k_in, pj_ff, pj_in;
   logic signed [31:0] u1_ff, u1_in, v1_ff, v1_in, u2_ff, u2_in;
   logic signed [31:0] u3_ff, u3_in, v2_ff, v2_in, v3_ff, v3_in;
   logic               alt_ff, alt_in;

   // memory and shared units
   logic               mem_we;
   logic [AW-1:0]      mem_waddr, mem_raddr;
   logic [95:0]        mem_wdata, mem_rdata;
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_full;
   logic               div_start;
   logic signed [31:0] div_num, div_den;
   div_result_type     div_res;

   // decisions
   logic signed [33:0] tol_p, tol_n, one_w;
   logic signed [31:0] d_acc, pk_w;
   logic               is_write, is_query, idx_ok, entry_ok;
   logic               k_done, k_self, in_dot, den_small, u2_small;
   logic               fail_i, fail_j, beta_fail, bb_fail, aa_fail, adv_k;
   logic [1:0]         jsel, ksel;
   logic [32:0]        ax, ay, az;

   tot_ram #(
      .WIDTH (96),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   tot_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .result (div_res)
   );

   assign is_write = (state_ff == ST_IDLE) && start && (req_payload.req_type == REQ_WRITE);
   assign is_query = (state_ff == ST_IDLE) && start && (req_payload.req_type == REQ_QUERY);
   assign idx_ok   = (17'(req_payload.from_index) < 17'(MAX_TRIANGLES))
                  && (17'(req_payload.to_index) < 17'(MAX_TRIANGLES));
   assign entry_ok = (17'(req_payload.entry_index) < 17'(MAX_TRIANGLES))
                  && (req_payload.vec_kind <= KIND_V3);

   // store one vector; kinds 5..7 and out-of-range entries are dropped
   assign mem_we    = is_write && entry_ok;
   assign mem_waddr = {EW'(req_payload.entry_index), req_payload.vec_kind};
   assign mem_wdata = {req_payload.comp_z, req_payload.comp_y, req_payload.comp_x};

   assign tol_p = {18'b0, tol_ff};
   assign tol_n = -tol_p;
   assign one_w = 34'sd1 <<< FRAC_BITS;
   assign d_acc = sat64(acc_ff);

   assign k_done = (17'(k_ff) >= 17'(count_ff)) || (17'(k_ff) >= 17'(MAX_TRIANGLES));
   assign k_self = (17'(k_ff) == 17'(from_ff)) || (17'(k_ff) == 17'(to_ff));
   assign in_dot = (state_ff == ST_DOT_I) || (state_ff == ST_DOT_J)
                || (state_ff == ST_K_DEN) || (state_ff == ST_K_NUM);

   assign fail_i    = ext34(d_acc) < tol_p;
   assign fail_j    = ext34(d_acc) > tol_n;
   assign den_small = (ext34(d_acc) < tol_p) && (ext34(d_acc) > tol_n);
   assign u2_small  = (ext34(u2_ff) < tol_p) && (ext34(u2_ff) > tol_n);
   assign beta_fail = div_res.zero || (ext34(div_res.quot) > one_w - tol_p)
                   || (ext34(div_res.quot) < tol_p);
   assign bb_fail   = div_res.zero || div_res.quot[31] || (ext34(div_res.quot) > one_w);
   assign aa_fail   = div_res.zero || div_res.quot[31]
                   || (ext34(div_res.quot) + ext34(bb_ff) > one_w);

   assign adv_k = ((state_ff == ST_K_SCAN) && !k_done && k_self)
               || ((state_ff == ST_K_CHK_DEN) && den_small)
               || ((state_ff == ST_K_WAIT_BETA) && div_res.done && beta_fail)
               || ((state_ff == ST_K_WAIT_B) && div_res.done && bb_fail)
               || ((state_ff == ST_K_WAIT_A) && div_res.done && aa_fail);

   // project onto the two axes other than the dominant normal axis
   assign ax = mag33(vec_comp(va_ff, 2'd0));
   assign ay = mag33(vec_comp(va_ff, 2'd1));
   assign az = mag33(vec_comp(va_ff, 2'd2));
   always_comb begin
      if (ax > ay) begin
         if (ax > az) begin
            jsel = 2'd1;
            ksel = 2'd2;
         end else begin
            jsel = 2'd0;
            ksel = 2'd1;
         end
      end else if (ay < az) begin
         jsel = 2'd0;
         ksel = 2'd1;
      end else begin
         jsel = 2'd0;
         ksel = 2'd2;
      end
   end

   // one shared multiplier; the floor shift is wiring
   assign mul_full = mul_a * mul_b;
   assign pk_w     = sat64(sx64(vec_comp(ci_ff, ksel)) + prod_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (is_query && idx_ok) state_in = ST_RD_CI;
         ST_RD_CI: state_in = ST_RD_CJ;
         ST_RD_CJ: state_in = ST_RD_NI;
         ST_RD_NI: state_in = ST_RD_NJ;
         ST_RD_NJ: state_in = ST_DOT_I;
         ST_DOT_I: if (sub_ff == 2'd3) state_in = ST_CHK_I;
         ST_CHK_I: state_in = fail_i ? ST_IDLE : ST_DOT_J;
         ST_DOT_J: if (sub_ff == 2'd3) state_in = ST_CHK_J;
         ST_CHK_J: state_in = fail_j ? ST_IDLE : ST_K_SCAN;
         ST_K_SCAN: begin
            priority if (k_done) state_in = ST_IDLE;
            else if (k_self) state_in = ST_K_SCAN;
            else state_in = ST_K_NK;
         end
         ST_K_NK: state_in = ST_K_DEN;
         ST_K_DEN: if (sub_ff == 2'd3) state_in = ST_K_CHK_DEN;
         ST_K_CHK_DEN: state_in = den_small ? ST_K_SCAN : ST_K_NUM;
         ST_K_NUM: if (sub_ff == 2'd3) state_in = ST_K_DIV_BETA;
         ST_K_DIV_BETA: state_in = ST_K_WAIT_BETA;
         ST_K_WAIT_BETA: if (div_res.done) state_in = beta_fail ? ST_K_SCAN : ST_K_RD_W2;
         ST_K_RD_W2: state_in = ST_K_RD_W3;
         ST_K_RD_W3: state_in = ST_K_PJ;
         ST_K_PJ: state_in = ST_K_PK;
         ST_K_PK: state_in = ST_K_UV;
         ST_K_UV: state_in = ST_K_BRANCH;
         ST_K_BRANCH: state_in = u2_small ? ST_K_WAIT_B : ST_K_N1;
         ST_K_N1: state_in = ST_K_N2;
         ST_K_N2: state_in = ST_K_N3;
         ST_K_N3: state_in = ST_K_N4;
         ST_K_N4: state_in = ST_K_N5;
         ST_K_N5: state_in = ST_K_WAIT_B;
         ST_K_WAIT_B: if (div_res.done) state_in = bb_fail ? ST_K_SCAN : ST_K_A1;
         ST_K_A1: state_in = ST_K_A2;
         ST_K_A2: state_in = ST_K_WAIT_A;
         ST_K_WAIT_A: if (div_res.done) state_in = aa_fail ? ST_K_SCAN : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      from_in = from_ff;
      to_in   = to_ff;
      k_in    = adv_k ? (k_ff + KW'(1)) : k_ff;
      sub_in  = in_dot ? (sub_ff + 2'd1) : 2'd0;
      ci_in   = ci_ff;
      s_in    = s_ff;
      sk_in   = sk_ff;
      va_in   = va_ff;
      nj_in   = nj_ff;
      t_in    = t_ff;
      den_in  = den_ff;
      beta_in = beta_ff;
      bb_in   = bb_ff;
      n_in    = n_ff;
      w1j_in  = w1j_ff;
      w1k_in  = w1k_ff;
      w2j_in  = w2j_ff;
      w2k_in  = w2k_ff;
      w3j_in  = w3j_ff;
      w3k_in  = w3k_ff;
      pj_in   = pj_ff;
      u1_in   = u1_ff;
      v1_in   = v1_ff;
      u2_in   = u2_ff;
      u3_in   = u3_ff;
      v2_in   = v2_ff;
      v3_in   = v3_ff;
      alt_in  = alt_ff;
      mul_a   = '0;
      mul_b   = '0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      mem_raddr = '0;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      if (in_dot) begin
         mul_a = vec_comp(va_ff, sub_ff);
         mul_b = vec_comp((state_ff == ST_K_NUM) ? sk_ff : s_ff, sub_ff);
      end
      acc_in = in_dot ? ((sub_ff == 2'd0) ? 64'sd0 : (acc_ff + prod_ff)) : acc_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (is_query) begin
               from_in = req_payload.from_index;
               to_in   = req_payload.to_index;
               if (!idx_ok) begin
                  rsp_valid_in         = 1'b1;
                  rsp_in.visible       = 1'b0;
                  rsp_in.status        = STATUS_NOT_FACING;
                  rsp_in.blocker_index = '0;
               end
            end
         end
         ST_RD_CI: mem_raddr = {EW'(from_ff), KIND_CENTER};
         ST_RD_CJ: begin
            mem_raddr = {EW'(to_ff), KIND_CENTER};
            ci_in     = mem_rdata;
         end
         ST_RD_NI: begin
            mem_raddr = {EW'(from_ff), KIND_NORMAL};
            s_in = {sub_sat(mem_rdata[95:64], ci_ff[95:64]),
                    sub_sat(mem_rdata[63:32], ci_ff[63:32]),
                    sub_sat(mem_rdata[31:0], ci_ff[31:0])};
         end
         ST_RD_NJ: begin
            mem_raddr = {EW'(to_ff), KIND_NORMAL};
            va_in     = mem_rdata;
         end
         ST_DOT_I: if (sub_ff == 2'd0) nj_in = mem_rdata;
         ST_CHK_I: begin
            va_in = nj_ff;
            if (fail_i) begin
               rsp_valid_in         = 1'b1;
               rsp_in.visible       = 1'b0;
               rsp_in.status        = STATUS_NOT_FACING;
               rsp_in.blocker_index = '0;
            end
         end
         ST_DOT_J: begin
         end
         ST_CHK_J: begin
            k_in = '0;
            if (fail_j) begin
               rsp_valid_in         = 1'b1;
               rsp_in.visible       = 1'b0;
               rsp_in.status        = STATUS_NOT_FACING;
               rsp_in.blocker_index = '0;
            end
         end
         ST_K_SCAN: begin
            mem_raddr = {EW'(k_ff), KIND_NORMAL};
            if (k_done) begin
               rsp_valid_in         = 1'b1;
               rsp_in.visible       = 1'b1;
               rsp_in.status        = STATUS_VISIBLE;
               rsp_in.blocker_index = '0;
            end
         end
         ST_K_NK: begin
            mem_raddr = {EW'(k_ff), KIND_CENTER};
            va_in     = mem_rdata;
         end
         ST_K_DEN: begin
            if (sub_ff == 2'd0) begin
               sk_in = {sub_sat(mem_rdata[95:64], ci_ff[95:64]),
                        sub_sat(mem_rdata[63:32], ci_ff[63:32]),
                        sub_sat(mem_rdata[31:0], ci_ff[31:0])};
            end
         end
         ST_K_CHK_DEN: den_in = d_acc;
         ST_K_NUM: begin
         end
         ST_K_DIV_BETA: begin
            div_start = 1'b1;
            div_num   = d_acc;
            div_den   = den_ff;
         end
         ST_K_WAIT_BETA: begin
            mem_raddr = {EW'(k_ff), KIND_V1};
            beta_in   = div_res.quot;
         end
         ST_K_RD_W2: begin
            mem_raddr = {EW'(k_ff), KIND_V2};
            w1j_in    = vec_comp(mem_rdata, jsel);
            w1k_in    = vec_comp(mem_rdata, ksel);
         end
         ST_K_RD_W3: begin
            mem_raddr = {EW'(k_ff), KIND_V3};
            w2j_in    = vec_comp(mem_rdata, jsel);
            w2k_in    = vec_comp(mem_rdata, ksel);
         end
         ST_K_PJ: begin
            w3j_in = vec_comp(mem_rdata, jsel);
            w3k_in = vec_comp(mem_rdata, ksel);
            mul_a  = vec_comp(s_ff, jsel);
            mul_b  = beta_ff;
         end
         ST_K_PK: begin
            pj_in = sat64(sx64(vec_comp(ci_ff, jsel)) + prod_ff);
            mul_a = vec_comp(s_ff, ksel);
            mul_b = beta_ff;
         end
         ST_K_UV: begin
            u1_in = sub_sat(pj_ff, w1j_ff);
            v1_in = sub_sat(pk_w, w1k_ff);
            u2_in = sub_sat(w2j_ff, w1j_ff);
            u3_in = sub_sat(w3j_ff, w1j_ff);
            v2_in = sub_sat(w2k_ff, w1k_ff);
            v3_in = sub_sat(w3k_ff, w1k_ff);
         end
         ST_K_BRANCH: begin
            // degenerate first edge: solve b from the u row alone
            alt_in = u2_small;
            if (u2_small) begin
               div_start = 1'b1;
               div_num   = u1_ff;
               div_den   = u3_ff;
            end
         end
         ST_K_N1: begin
            mul_a = v1_ff;
            mul_b = u2_ff;
         end
         ST_K_N2: begin
            t_in  = prod_ff;
            mul_a = u1_ff;
            mul_b = v2_ff;
         end
         ST_K_N3: begin
            n_in  = sat64(t_ff - prod_ff);
            mul_a = v3_ff;
            mul_b = u2_ff;
         end
         ST_K_N4: begin
            t_in  = prod_ff;
            mul_a = u3_ff;
            mul_b = v2_ff;
         end
         ST_K_N5: begin
            div_start = 1'b1;
            div_num   = n_ff;
            div_den   = sat64(t_ff - prod_ff);
         end
         ST_K_WAIT_B: bb_in = div_res.quot;
         ST_K_A1: begin
            mul_a = bb_ff;
            mul_b = alt_ff ? v3_ff : u3_ff;
         end
         ST_K_A2: begin
            div_start = 1'b1;
            div_num   = sat64(sx64(alt_ff ? v1_ff : u1_ff) - prod_ff);
            div_den   = alt_ff ? v2_ff : u2_ff;
         end
         ST_K_WAIT_A: begin
            if (div_res.done && !aa_fail) begin
               rsp_valid_in         = 1'b1;
               rsp_in.visible       = 1'b0;
               rsp_in.status        = STATUS_OCCLUDED;
               rsp_in.blocker_index = 10'(k_ff);
            end
         end
         default: begin
         end
      endcase

      prod_in = mul_full >>> FRAC_BITS;
   end

   // control registers
   always_comb begin
      count_in = count_ff;
      tol_in   = tol_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TRIANGLE_COUNT: count_in = csr_wdata[10:0];
            CSR_TOLERANCE:      tol_in   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         tol_ff       <= 16'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         tol_ff       <= tol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      from_ff <= from_in;
      to_ff   <= to_in;
      k_ff    <= k_in;
      sub_ff  <= sub_in;
      ci_ff   <= ci_in;
      s_ff    <= s_in;
      sk_ff   <= sk_in;
      va_ff   <= va_in;
      nj_ff   <= nj_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      t_ff    <= t_in;
      den_ff  <= den_in;
      beta_ff <= beta_in;
      bb_ff   <= bb_in;
      n_ff    <= n_in;
      w1j_ff  <= w1j_in;
      w1k_ff  <= w1k_in;
      w2j_ff  <= w2j_in;
      w2k_ff  <= w2k_in;
      w3j_ff  <= w3j_in;
      w3k_ff  <= w3k_in;
      pj_ff   <= pj_in;
      u1_ff   <= u1_in;
      v1_ff   <= v1_in;
      u2_ff   <= u2_in;
      u3_ff   <= u3_in;
      v2_ff   <= v2_in;
      v3_ff   <= v3_in;
      alt_ff  <= alt_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ rtl/tot_checker.sv @@
`timescale 1ns / 1ps
module tot_checker
   import tot_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            start,
   input logic            busy,
   input req_payload_type req_payload,
   input logic            rsp_strobe,
   input rsp_payload_type rsp_payload
);

   // a write transaction never produces an answer
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_payload.req_type == REQ_WRITE)) |=> !rsp_strobe)
      else $error("answer after a write transaction");

   // an accepted query either answers at once or keeps the block busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_payload.req_type == REQ_QUERY)) |=> (busy || rsp_strobe))
      else $error("query dropped");

   // leaving busy always delivers the answer
   assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_strobe)
      else $error("busy fell without an answer");

   // answer fields agree with each other
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_payload.visible == (rsp_payload.status == STATUS_VISIBLE))
         && (rsp_payload.status != 2'd3)
         && ((rsp_payload.status == STATUS_OCCLUDED) || (rsp_payload.blocker_index == '0))))
      else $error("inconsistent answer fields");

endmodule

bind triangle_occlusion_test_top tot_checker u_tot_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
   import tot_pkg::*;

   localparam int NTRI = 1024;
   localparam int FB   = 16;
   localparam longint ONE = 64'sd1 << FB;
   localparam int USED = 8;   // entries loaded and queried by the directed and random phases

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            start = 1'b0;
   logic            busy;
   req_payload_type req_payload = '0;
   logic            rsp_strobe;
   rsp_payload_type rsp_payload;
   logic            csr_we = 1'b0;
   logic            csr_index = CSR_TRIANGLE_COUNT;
   logic [15:0]     csr_wdata = '0;

   triangle_occlusion_test_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // Fail the run if it hangs.
   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Shadow of the block: stored vectors and the two control registers.
   // ---------------------------------------------------------------------
   logic signed [31:0] center_mem [NTRI][3];
   logic signed [31:0] normal_mem [NTRI][3];
   logic signed [31:0] vertex_mem [NTRI][9];
   logic [10:0]        tri_count = 11'd0;
   logic [15:0]        eps = 16'd1;

   rsp_payload_type answers_due [$];
   int mismatches = 0;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Fixed-point product, floor of the shifted exact product.
   function automatic longint fmul(longint a, longint b);
      return (a * b) >>> FB;
   endfunction

   function automatic longint fdot(longint a [3], longint b [3]);
      return clamp32(fmul(a[0], b[0]) + fmul(a[1], b[1]) + fmul(a[2], b[2]));
   endfunction

   // Quotient truncated toward zero; a zero divisor reports no result.
   function automatic bit fdiv(longint n, longint d, output longint q);
      q = 0;
      if (d == 0) return 1'b0;
      q = clamp32((n * ONE) / d);
      return 1'b1;
   endfunction

   function automatic rsp_payload_type sight_answer(int src, int dst);
      rsp_payload_type r;
      longint tl, ci [3], cj [3], ni [3], nj [3], s [3];
      longint nk [3], sk [3], w1 [3], w2 [3], w3 [3];
      longint den, beta, ax, ay, az, pj, pk, u1, v1, u2, u3, v2, v3, bb, aa, n, d;
      int cnt, jj, kk;
      r = '0;
      tl = longint'(eps);
      for (int a = 0; a < 3; a++) begin
         ci[a] = center_mem[src][a];
         cj[a] = center_mem[dst][a];
         ni[a] = normal_mem[src][a];
         nj[a] = normal_mem[dst][a];
         s[a]  = clamp32(cj[a] - ci[a]);
      end
      if (fdot(ni, s) < tl || fdot(nj, s) > -tl) begin
         r.status = STATUS_NOT_FACING;
         return r;
      end
      cnt = (tri_count > NTRI) ? NTRI : int'(tri_count);
      for (int k = 0; k < cnt; k++) begin
         if (k == src || k == dst) continue;
         for (int a = 0; a < 3; a++) nk[a] = normal_mem[k][a];
         den = fdot(nk, s);
         if (den < tl && den > -tl) continue;   // plane parallel to the segment
         for (int a = 0; a < 3; a++) sk[a] = clamp32(longint'(center_mem[k][a]) - ci[a]);
         if (!fdiv(fdot(nk, sk), den, beta)) continue;
         if (beta > ONE - tl || beta < tl) continue;
         ax = nk[0] < 0 ? -nk[0] : nk[0];
         ay = nk[1] < 0 ? -nk[1] : nk[1];
         az = nk[2] < 0 ? -nk[2] : nk[2];
         if (ax > ay) begin
            if (ax > az) begin jj = 1; kk = 2; end else begin jj = 0; kk = 1; end
         end else begin
            if (ay < az) begin jj = 0; kk = 1; end else begin jj = 0; kk = 2; end
         end
         for (int a = 0; a < 3; a++) begin
            w1[a] = vertex_mem[k][a];
            w2[a] = vertex_mem[k][3 + a];
            w3[a] = vertex_mem[k][6 + a];
         end
         pj = clamp32(ci[jj] + fmul(s[jj], beta));
         pk = clamp32(ci[kk] + fmul(s[kk], beta));
         u1 = clamp32(pj - w1[jj]);
         v1 = clamp32(pk - w1[kk]);
         u2 = clamp32(w2[jj] - w1[jj]);
         u3 = clamp32(w3[jj] - w1[jj]);
         v2 = clamp32(w2[kk] - w1[kk]);
         v3 = clamp32(w3[kk] - w1[kk]);
         if (u2 > -tl && u2 < tl) begin
            // degenerate first edge: solve for b from the other edge first
            if (!fdiv(u1, u3, bb)) continue;
            if (bb < 0 || bb > ONE) continue;
            if (!fdiv(clamp32(v1 - fmul(bb, v3)), v2, aa)) continue;
         end else begin
            n = clamp32(fmul(v1, u2) - fmul(u1, v2));
            d = clamp32(fmul(v3, u2) - fmul(u3, v2));
            if (!fdiv(n, d, bb)) continue;
            if (bb < 0 || bb > ONE) continue;
            if (!fdiv(clamp32(u1 - fmul(bb, u3)), u2, aa)) continue;
         end
         if (aa < 0 || aa + bb > ONE) continue;
         r.status = STATUS_OCCLUDED;
         r.blocker_index = k[9:0];
         return r;
      end
      r.visible = 1'b1;
      r.status  = STATUS_VISIBLE;
      return r;
   endfunction

   // Apply one accepted transaction to the shadow; queries queue their answer.
   task automatic track_transaction(req_payload_type t, bit typed, rsp_payload_type want);
      int e;
      e = int'(t.entry_index);
      if (t.req_type == REQ_QUERY) begin
         answers_due.push_back(typed ? want
                                     : sight_answer(int'(t.from_index), int'(t.to_index)));
      end else begin
         case (t.vec_kind)
            KIND_CENTER: begin
               center_mem[e][0] = t.comp_x; center_mem[e][1] = t.comp_y;
               center_mem[e][2] = t.comp_z;
            end
            KIND_NORMAL: begin
               normal_mem[e][0] = t.comp_x; normal_mem[e][1] = t.comp_y;
               normal_mem[e][2] = t.comp_z;
            end
            KIND_V1, KIND_V2, KIND_V3: begin
               vertex_mem[e][(t.vec_kind - KIND_V1) * 3]     = t.comp_x;
               vertex_mem[e][(t.vec_kind - KIND_V1) * 3 + 1] = t.comp_y;
               vertex_mem[e][(t.vec_kind - KIND_V1) * 3 + 2] = t.comp_z;
            end
            default: ;   // unknown kind: drop
         endcase
      end
   endtask

   // Compare each answer with the oldest one due.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (answers_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected answer %p", rsp_payload);
         end else begin
            if (rsp_payload.visible !== answers_due[0].visible
                || rsp_payload.status !== answers_due[0].status
                || rsp_payload.blocker_index !== answers_due[0].blocker_index) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("answer mismatch: expected %p, got %p", answers_due[0],
                           rsp_payload);
            end
            void'(answers_due.pop_front());
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   bit no_gaps = 0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   // Present one transaction; hold start high across back-to-back items.
   task automatic issue(req_payload_type t, int gap, bit typed = 0,
                        rsp_payload_type want = '0);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_payload <= t;
      do @(posedge clock); while (busy);
      track_transaction(t, typed, want);
   endtask

   // Drop start and wait until the block is idle and every answer is in.
   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      wait (answers_due.size() == 0);
      repeat (20) @(posedge clock);
      wait (!busy);
      @(negedge clock);
   endtask

   task automatic csr_write(logic idx, logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_TRIANGLE_COUNT) tri_count = val[10:0];
      else eps = val;
   endtask

   function automatic req_payload_type vec_item(int e, logic [2:0] kind,
                                                longint x, longint y, longint z);
      req_payload_type t;
      t = '0;
      t.req_type = REQ_WRITE;
      t.entry_index = e[9:0];
      t.vec_kind = kind;
      t.comp_x = x[31:0]; t.comp_y = y[31:0]; t.comp_z = z[31:0];
      t.from_index = 10'($urandom);
      t.to_index = 10'($urandom);
      return t;
   endfunction

   function automatic req_payload_type query_item(int src, int dst);
      req_payload_type t;
      t = '0;
      t.req_type = REQ_QUERY;
      t.entry_index = 10'($urandom);
      t.vec_kind = 3'($urandom);
      t.comp_x = $urandom; t.comp_y = $urandom; t.comp_z = $urandom;
      t.from_index = src[9:0];
      t.to_index = dst[9:0];
      return t;
   endfunction

   function automatic longint jitter(longint span);
      return longint'($urandom_range(0, 2 * span)) - span;
   endfunction

   // Scene-shaped vector: centers along x, normals near +-x, vertices on a
   // small yz grid so that crossings, misses and degenerate edges all occur.
   function automatic req_payload_type scene_item(int e, logic [2:0] kind);
      longint x, y, z;
      case (kind)
         KIND_CENTER: begin
            x = $urandom_range(0, 8 * ONE); y = jitter(ONE / 8); z = jitter(ONE / 8);
         end
         KIND_NORMAL: begin
            x = $urandom_range(0, 1) ? ONE : -ONE; y = jitter(ONE / 4); z = jitter(ONE / 4);
         end
         default: begin
            x = $urandom_range(0, 8 * ONE);
            y = (longint'($urandom_range(0, 4)) - 2) * ONE;
            z = (longint'($urandom_range(0, 4)) - 2) * ONE;
            if ($urandom_range(0, 1)) begin y += jitter(ONE / 2); z += jitter(ONE / 2); end
         end
      endcase
      return vec_item(e, kind, x, y, z);
   endfunction

   task automatic load_scene(int lo, int hi);
      for (int e = lo; e <= hi; e++)
         for (int k = 0; k <= 4; k++) issue(scene_item(e, 3'(k)), pick_gap());
   endtask

   // ---------------------------------------------------------------------
   // Directed table
   // ---------------------------------------------------------------------
   typedef struct {
      bit              is_csr;
      logic            reg_idx;
      logic [15:0]     reg_val;
      req_payload_type item;
      bit              typed;
      rsp_payload_type want;
   } step_row_t;

   step_row_t plan [$];

   function automatic step_row_t vrow(int e, logic [2:0] kind, longint x, longint y,
                                      longint z);
      step_row_t r;
      r = '{default: '0};
      r.item = vec_item(e, kind, x, y, z);
      return r;
   endfunction

   function automatic step_row_t qrow(int src, int dst, bit typed,
                                      logic [1:0] st, int blk);
      step_row_t r;
      r = '{default: '0};
      r.item = query_item(src, dst);
      r.typed = typed;
      r.want.visible = (st == STATUS_VISIBLE);
      r.want.status = st;
      r.want.blocker_index = blk[9:0];
      return r;
   endfunction

   function automatic step_row_t crow(logic idx, logic [15:0] val);
      step_row_t r;
      r = '{default: '0};
      r.is_csr = 1'b1;
      r.reg_idx = idx;
      r.reg_val = val;
      return r;
   endfunction

   initial begin
      req_payload_type t;
      int n_rsp, src, dst, r;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Source at x=0 facing +x, target at x=4 facing -x, blocker at x=2
      // whose triangle contains the yz origin.
      plan.push_back(vrow(0, KIND_CENTER, 0, 0, 0));
      plan.push_back(vrow(0, KIND_NORMAL, ONE, 0, 0));
      plan.push_back(vrow(0, KIND_V1, 0, -ONE, -ONE));
      plan.push_back(vrow(0, KIND_V2, 0, ONE, 0));
      plan.push_back(vrow(0, KIND_V3, 0, -ONE, ONE));
      plan.push_back(vrow(1, KIND_CENTER, 4 * ONE, 0, 0));
      plan.push_back(vrow(1, KIND_NORMAL, -ONE, 0, 0));
      plan.push_back(vrow(1, KIND_V1, 4 * ONE, -ONE, -ONE));
      plan.push_back(vrow(1, KIND_V2, 4 * ONE, ONE, 0));
      plan.push_back(vrow(1, KIND_V3, 4 * ONE, -ONE, ONE));
      plan.push_back(vrow(2, KIND_CENTER, 2 * ONE, 0, 0));
      plan.push_back(vrow(2, KIND_NORMAL, ONE, 0, 0));
      plan.push_back(vrow(2, KIND_V1, 2 * ONE, -ONE, -ONE));
      plan.push_back(vrow(2, KIND_V2, 2 * ONE, 2 * ONE, 0));
      plan.push_back(vrow(2, KIND_V3, 2 * ONE, -ONE, 2 * ONE));
      plan.push_back(qrow(0, 0, 1, STATUS_NOT_FACING, 0));   // same source and target
      plan.push_back(qrow(0, 1, 1, STATUS_VISIBLE, 0));      // nothing scanned after reset
      plan.push_back(crow(CSR_TRIANGLE_COUNT, 16'd3));
      plan.push_back(qrow(0, 1, 1, STATUS_OCCLUDED, 2));
      plan.push_back(qrow(1, 0, 1, STATUS_OCCLUDED, 2));
      plan.push_back(vrow(2, 3'd7, 64'sh7FFFFFFF, -64'sd2147483648, 0));  // unknown kind
      plan.push_back(qrow(0, 1, 1, STATUS_OCCLUDED, 2));
      // degenerate first edge, then a zero divisor on the alternate solve
      plan.push_back(vrow(2, KIND_V2, 2 * ONE, -ONE, 3 * ONE));
      plan.push_back(vrow(2, KIND_V3, 2 * ONE, 2 * ONE, -ONE));
      plan.push_back(qrow(0, 1, 0, 0, 0));
      plan.push_back(vrow(2, KIND_V3, 2 * ONE, -ONE, -2 * ONE));
      plan.push_back(qrow(0, 1, 0, 0, 0));
      plan.push_back(vrow(5, KIND_CENTER, 64'sh7FFFFFFF, -64'sd2147483648, -1));
      plan.push_back(crow(CSR_TOLERANCE, 16'hFFFF));
      plan.push_back(qrow(0, 1, 0, 0, 0));
      plan.push_back(crow(CSR_TOLERANCE, 16'h0000));
      plan.push_back(qrow(0, 1, 0, 0, 0));

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            settle();
            csr_write(plan[i].reg_idx, plan[i].reg_val);
         end else begin
            issue(plan[i].item, pick_gap(), plan[i].typed, plan[i].want);
         end
      end
      settle();

      // Random phases over a small scene, each under its own settings.
      load_scene(0, USED - 1);
      n_rsp = 0;
      for (int ph = 0; ph < 4; ph++) begin
         settle();
         case (ph)
            0: begin
               csr_write(CSR_TRIANGLE_COUNT, 16'(USED));
               csr_write(CSR_TOLERANCE, 16'd1);
            end
            1: begin csr_write(CSR_TRIANGLE_COUNT, 16'd0); csr_write(CSR_TOLERANCE, 16'd0); end
            2: begin
               csr_write(CSR_TRIANGLE_COUNT, 16'($urandom_range(1, USED)));
               csr_write(CSR_TOLERANCE, 16'($urandom_range(0, 4096)));
            end
            default: begin
               csr_write(CSR_TRIANGLE_COUNT, 16'(USED));
               csr_write(CSR_TOLERANCE, 16'($urandom_range(1, 64)));
            end
         endcase
         no_gaps = (ph == 3);
         for (int i = 0; i < 8; i++) begin
            r = $urandom_range(0, 99);
            if (i == 4) begin
               // hold off until every answer is back
               @(negedge clock);
               start <= 1'b0;
               wait (answers_due.size() == 0);
            end
            if (r < 40) begin
               t = scene_item($urandom_range(0, USED - 1), 3'($urandom_range(0, 4)));
            end else if (r < 50) begin
               // noise: any kind, any entry, any bits
               t = vec_item($urandom_range(0, 1023), 3'($urandom), 0, 0, 0);
               t.comp_x = $urandom; t.comp_y = $urandom; t.comp_z = $urandom;
               if (t.entry_index < USED && t.vec_kind > KIND_V3) t.vec_kind = 3'd6;
            end else begin
               src = $urandom_range(0, USED - 1);
               dst = ($urandom_range(0, 9) == 0) ? src : $urandom_range(0, USED - 1);
               t = query_item(src, dst);
            end
            issue(t, pick_gap());
         end
      end
      no_gaps = 0;

      settle();
      repeat (200) @(posedge clock);

      if (mismatches == 0 && answers_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
